@@ hw/rtl/c3sf_pkg.sv @@
// ----------------------------------------------------------------------------
// c3sf_pkg: shared types and constants for the 3x3 stream filter
// Pixel, window and coefficient types, arithmetic widths, register indexes
// and register reset values.
// ----------------------------------------------------------------------------
package c3sf_pkg;

   localparam int KS         = 3;
   localparam int HALF_K     = 2;
   localparam int PIX_W      = 8;
   localparam int COEF_W     = 16;
   localparam int ROW_W      = KS * COEF_W;
   localparam int GEO_W      = 13;
   localparam int IMG_W_W    = 11;
   localparam int IMG_H_W    = 13;
   localparam int MAX_HEIGHT = 4096;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = ROW_W;
   localparam int FRAC_W     = 12;
   localparam int PROD_W     = PIX_W + 1 + COEF_W;
   localparam int ROWSUM_W   = PROD_W + 2;
   localparam int SUM_W      = ROWSUM_W + 1;
   localparam int WORD_W     = 2 * PIX_W;

   localparam logic [PIX_W-1:0] PIX_MAX        = '1;
   localparam logic [GEO_W-1:0] WIDTH_RST      = 13'd640;
   localparam logic [GEO_W-1:0] HEIGHT_RST     = 13'd480;
   localparam logic [ROW_W-1:0] COEF_TOP_RST   = 48'h0000_0000_0000;
   localparam logic [ROW_W-1:0] COEF_MID_RST   = 48'h0000_1000_0000;
   localparam logic [ROW_W-1:0] COEF_BOT_RST   = 48'h0000_0000_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 3'd0,
      CSR_IMAGE_HEIGHT = 3'd1,
      CSR_BORDER_MODE  = 3'd2,
      CSR_COEF_TOP     = 3'd3,
      CSR_COEF_MID     = 3'd4,
      CSR_COEF_BOT     = 3'd5
   } csr_index_type;

   typedef logic [PIX_W-1:0]                   pix_type;
   typedef logic [KS-1:0][PIX_W-1:0]           col_type;
   typedef logic [KS-1:0][KS-1:0][PIX_W-1:0]   win_type;
   typedef logic [KS-1:0][KS-1:0]              mask_type;
   typedef logic [KS-1:0][ROW_W-1:0]           coef_type;

   typedef struct packed {
      logic ld_s2;
      logic ld_s3;
      logic ld_s4;
      logic ld_out;
   } mac_ctl_type;

endpackage

@@ hw/rtl/c3sf_line_mem.sv @@
// ----------------------------------------------------------------------------
// c3sf_line_mem: line store memory
// One write port and one read port; read data is registered.
// Each word holds the two previous rows of one column.
// ----------------------------------------------------------------------------
module c3sf_line_mem #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/c3sf_window.sv @@
// ----------------------------------------------------------------------------
// c3sf_window: 3x3 pixel window
// Shifts one column left per pixel and loads the newest column on the right.
// ----------------------------------------------------------------------------
module c3sf_window (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift_en,
   input  c3sf_pkg::col_type col_new,
   output c3sf_pkg::win_type win_new
);

   c3sf_pkg::win_type win_ff;
   c3sf_pkg::win_type win_in;

   always_comb begin
      for (int kr = 0; kr < c3sf_pkg::KS; kr++) begin
         for (int kc = 0; kc < c3sf_pkg::KS - 1; kc++) begin
            win_in[kr][kc] = win_ff[kr][kc+1];
         end
         win_in[kr][c3sf_pkg::KS-1] = col_new[kr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (shift_en) begin
         win_ff <= win_in;
      end
   end

   assign win_new = win_in;

endmodule

@@ hw/rtl/c3sf_mac.sv @@
// ----------------------------------------------------------------------------
// c3sf_mac: multiply-accumulate pipeline
// Masks the window, forms nine pixel by coefficient products, sums per row,
// then sums the rows, scales by 2^-12 and clamps to the pixel range.
// ----------------------------------------------------------------------------
module c3sf_mac (
   input  logic                  clock,
   input  c3sf_pkg::mac_ctl_type ctl,
   input  c3sf_pkg::win_type     win,
   input  c3sf_pkg::mask_type    mask,
   input  logic                  last,
   input  c3sf_pkg::coef_type    coefs,
   output logic [c3sf_pkg::PIX_W-1:0] pixel_out,
   output logic                  frame_last
);

   localparam int Q_W = c3sf_pkg::SUM_W - c3sf_pkg::FRAC_W;

   c3sf_pkg::pix_type px_in [c3sf_pkg::KS][c3sf_pkg::KS];
   c3sf_pkg::pix_type px_ff [c3sf_pkg::KS][c3sf_pkg::KS];
   logic signed [c3sf_pkg::PROD_W-1:0]   prod_in [c3sf_pkg::KS][c3sf_pkg::KS];
   logic signed [c3sf_pkg::PROD_W-1:0]   prod_ff [c3sf_pkg::KS][c3sf_pkg::KS];
   logic signed [c3sf_pkg::ROWSUM_W-1:0] rsum_in [c3sf_pkg::KS];
   logic signed [c3sf_pkg::ROWSUM_W-1:0] rsum_ff [c3sf_pkg::KS];
   logic signed [c3sf_pkg::SUM_W-1:0]    total;
   logic [Q_W-1:0]                       quot;
   logic [c3sf_pkg::PIX_W-1:0]           pix_out_in;
   logic [c3sf_pkg::PIX_W-1:0]           pix_out_ff;
   logic last2_ff, last3_ff, last4_ff, last_out_ff;

   always_comb begin
      for (int kr = 0; kr < c3sf_pkg::KS; kr++) begin
         for (int kc = 0; kc < c3sf_pkg::KS; kc++) begin
            px_in[kr][kc] = mask[kr][kc] ? win[kr][kc] : '0;
         end
      end
   end

   always_comb begin
      for (int kr = 0; kr < c3sf_pkg::KS; kr++) begin
         for (int kc = 0; kc < c3sf_pkg::KS; kc++) begin
            prod_in[kr][kc] =
               $signed({{(c3sf_pkg::PROD_W - c3sf_pkg::PIX_W){1'b0}}, px_ff[kr][kc]}) *
               $signed({{(c3sf_pkg::PROD_W - c3sf_pkg::COEF_W)
                          {coefs[kr][kc*c3sf_pkg::COEF_W + c3sf_pkg::COEF_W - 1]}},
                        coefs[kr][kc*c3sf_pkg::COEF_W +: c3sf_pkg::COEF_W]});
         end
      end
   end

   always_comb begin
      for (int kr = 0; kr < c3sf_pkg::KS; kr++) begin
         rsum_in[kr] = '0;
         for (int kc = 0; kc < c3sf_pkg::KS; kc++) begin
            rsum_in[kr] = rsum_in[kr] + c3sf_pkg::ROWSUM_W'(prod_ff[kr][kc]);
         end
      end
   end

   always_comb begin
      total = '0;
      for (int kr = 0; kr < c3sf_pkg::KS; kr++) begin
         total = total + c3sf_pkg::SUM_W'(rsum_ff[kr]);
      end
      quot = total[c3sf_pkg::SUM_W-1:c3sf_pkg::FRAC_W];
      if (total[c3sf_pkg::SUM_W-1]) begin
         pix_out_in = '0;
      end else if (quot > Q_W'(c3sf_pkg::PIX_MAX)) begin
         pix_out_in = c3sf_pkg::PIX_MAX;
      end else begin
         pix_out_in = quot[c3sf_pkg::PIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_s2) begin
         px_ff    <= px_in;
         last2_ff <= last;
      end
      if (ctl.ld_s3) begin
         prod_ff  <= prod_in;
         last3_ff <= last2_ff;
      end
      if (ctl.ld_s4) begin
         rsum_ff  <= rsum_in;
         last4_ff <= last3_ff;
      end
      if (ctl.ld_out) begin
         pix_out_ff  <= pix_out_in;
         last_out_ff <= last4_ff;
      end
   end

   assign pixel_out  = pix_out_ff;
   assign frame_last = last_out_ff;

endmodule

@@ hw/rtl/conv3x3_stream_filter_unit.sv @@
// ----------------------------------------------------------------------------
// conv3x3_stream_filter_unit: streaming 3x3 convolution over 8-bit pixels
// Pipeline: the item that produces a result passes through the line store read,
// window, products, row sums and output registers before rsp_valid rises.
// Throughput: one item per cycle while the output is not stalled, set by the line
// store read-modify-write (one read and one write of the column word per item,
// forwarded on reuse). Reset: synchronous; clears position counters, window and
// pipeline valids and loads register defaults. Line stores are not cleared (no clearing pass).
// ----------------------------------------------------------------------------
module conv3x3_stream_filter_unit #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_action,
   input  logic [c3sf_pkg::PIX_W-1:0]          req_pixel_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [c3sf_pkg::PIX_W-1:0]          rsp_pixel_out,
   output logic                                rsp_frame_last,
   input  logic                                csr_write_en,
   input  logic [c3sf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [c3sf_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int ADDR_W = $clog2(MAX_WIDTH);
   localparam int GW     = c3sf_pkg::GEO_W;
   localparam logic [GW-1:0] MAX_W_GEO = GW'(MAX_WIDTH);
   localparam logic [GW-1:0] MAX_H_GEO = GW'(c3sf_pkg::MAX_HEIGHT);
   localparam logic [GW-1:0] ONE_GEO   = GW'(1);

   // configuration
   logic [GW-1:0]      w_eff_ff, w_eff_in;
   logic [GW-1:0]      h_eff_ff, h_eff_in;
   logic               border_ff, border_in;
   c3sf_pkg::coef_type coef_ff, coef_in;
   logic               geo_clear;
   logic [GW-1:0]      csr_w, csr_h;

   // position counters
   logic [ADDR_W-1:0]  col_ff, col_in;
   logic [GW-1:0]      row_ff, row_in;

   // intake
   logic               rdy1, rdy2, rdy3, rdy4, ld_out;
   logic               accept, proc;
   logic [GW-1:0]      col_g, col_inc, wm1, hm1, ro, co;
   logic               row_lt_h, case_a, case_b, emit, last, border;
   logic [c3sf_pkg::KS-1:0] row_ok, col_ok;
   c3sf_pkg::mask_type mask_in;
   c3sf_pkg::pix_type  pix0;
   logic               fwd_in;
   logic [c3sf_pkg::WORD_W-1:0] fwd_word_in;

   // stage 1: line store data returns
   logic               s1_v_ff, s1_emit_ff, s1_last_ff, s1_fwd_ff;
   logic [ADDR_W-1:0]  s1_addr_ff;
   c3sf_pkg::pix_type  s1_pix_ff;
   c3sf_pkg::mask_type s1_mask_ff;
   logic [c3sf_pkg::WORD_W-1:0] s1_fwd_word_ff;
   logic [c3sf_pkg::WORD_W-1:0] rd_word, cur_word, wr_word;
   logic               s1_wr;
   c3sf_pkg::pix_type  a_cur, b_cur;
   c3sf_pkg::col_type  col_new;
   c3sf_pkg::win_type  win_new;

   // later stage valids
   logic               v2_ff, v3_ff, v4_ff, rsp_valid_ff;
   c3sf_pkg::mac_ctl_type mac_ctl;

   // ------------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------------
   always_comb begin
      csr_w     = GW'(csr_data[c3sf_pkg::IMG_W_W-1:0]);
      csr_h     = GW'(csr_data[c3sf_pkg::IMG_H_W-1:0]);
      w_eff_in  = w_eff_ff;
      h_eff_in  = h_eff_ff;
      border_in = border_ff;
      coef_in   = coef_ff;
      geo_clear = 1'b0;
      if (csr_write_en) begin
         unique case (csr_index)
            c3sf_pkg::CSR_IMAGE_WIDTH: begin
               geo_clear = 1'b1;
               if (csr_w == '0) begin
                  w_eff_in = ONE_GEO;
               end else if (csr_w > MAX_W_GEO) begin
                  w_eff_in = MAX_W_GEO;
               end else begin
                  w_eff_in = csr_w;
               end
            end
            c3sf_pkg::CSR_IMAGE_HEIGHT: begin
               geo_clear = 1'b1;
               if (csr_h == '0) begin
                  h_eff_in = ONE_GEO;
               end else if (csr_h > MAX_H_GEO) begin
                  h_eff_in = MAX_H_GEO;
               end else begin
                  h_eff_in = csr_h;
               end
            end
            c3sf_pkg::CSR_BORDER_MODE: border_in = csr_data[0];
            c3sf_pkg::CSR_COEF_TOP:    coef_in[0] = csr_data;
            c3sf_pkg::CSR_COEF_MID:    coef_in[1] = csr_data;
            c3sf_pkg::CSR_COEF_BOT:    coef_in[2] = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_eff_ff  <= c3sf_pkg::WIDTH_RST;
         h_eff_ff  <= c3sf_pkg::HEIGHT_RST;
         border_ff <= 1'b0;
         coef_ff   <= {c3sf_pkg::COEF_BOT_RST, c3sf_pkg::COEF_MID_RST,
                       c3sf_pkg::COEF_TOP_RST};
      end else begin
         w_eff_ff  <= w_eff_in;
         h_eff_ff  <= h_eff_in;
         border_ff <= border_in;
         coef_ff   <= coef_in;
      end
   end

   // ------------------------------------------------------------------------
   // pipeline flow
   // ------------------------------------------------------------------------
   assign ld_out    = !rsp_valid_ff || !rsp_stall;
   assign rdy4      = !v4_ff || ld_out;
   assign rdy3      = !v3_ff || rdy4;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !s1_v_ff || rdy2;
   assign req_stall = !rdy1;
   assign s1_wr     = s1_v_ff && rdy2;

   // ------------------------------------------------------------------------
   // intake: positions, emission, mask
   // ------------------------------------------------------------------------
   always_comb begin
      accept   = req_valid && !req_stall;
      col_g    = GW'(col_ff);
      wm1      = w_eff_ff - ONE_GEO;
      hm1      = h_eff_ff - ONE_GEO;
      row_lt_h = row_ff < h_eff_ff;
      proc     = accept && !(req_action && row_lt_h);
      case_a   = (col_ff == '0) && (row_ff >= GW'(c3sf_pkg::HALF_K));
      case_b   = (col_ff != '0) && (row_ff >= ONE_GEO);
      emit     = case_a || case_b;
      ro       = case_a ? row_ff - GW'(c3sf_pkg::HALF_K) : row_ff - ONE_GEO;
      co       = case_a ? wm1 : col_g - ONE_GEO;
      last     = emit && (ro == hm1) && (co == wm1);
      border   = border_ff && ((ro == '0) || (co == '0) || (ro == hm1) || (co == wm1));
      row_ok   = {ro < hm1, ro < h_eff_ff, ro != '0};
      col_ok   = {co < wm1, co < w_eff_ff, co != '0};
      for (int kr = 0; kr < c3sf_pkg::KS; kr++) begin
         for (int kc = 0; kc < c3sf_pkg::KS; kc++) begin
            mask_in[kr][kc] = !border && row_ok[kr] && col_ok[kc];
         end
      end
      pix0        = row_lt_h ? req_pixel_in : '0;
      fwd_in      = s1_wr && (s1_addr_ff == col_ff);
      fwd_word_in = wr_word;

      col_inc = col_g + ONE_GEO;
      col_in  = col_ff;
      row_in  = row_ff;
      if (geo_clear) begin
         col_in = '0;
         row_in = '0;
      end else if (proc) begin
         if (last) begin
            col_in = '0;
            row_in = '0;
         end else if (col_inc == w_eff_ff) begin
            col_in = '0;
            row_in = row_ff + ONE_GEO;
         end else begin
            col_in = col_inc[ADDR_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (rdy1) begin
         s1_v_ff <= proc;
      end
      if (rdy1) begin
         s1_addr_ff     <= col_ff;
         s1_pix_ff      <= pix0;
         s1_emit_ff     <= emit;
         s1_last_ff     <= last;
         s1_mask_ff     <= mask_in;
         s1_fwd_ff      <= fwd_in;
         s1_fwd_word_ff <= fwd_word_in;
      end
   end

   // ------------------------------------------------------------------------
   // stage 1: read-modify-write of the column word, window shift
   // ------------------------------------------------------------------------
   c3sf_line_mem #(
      .DEPTH  (MAX_WIDTH),
      .ADDR_W (ADDR_W),
      .DATA_W (c3sf_pkg::WORD_W)
   ) u_line_mem (
      .clock   (clock),
      .rd_en   (rdy1),
      .rd_addr (col_ff),
      .rd_data (rd_word),
      .wr_en   (s1_wr),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_word)
   );

   always_comb begin
      cur_word   = s1_fwd_ff ? s1_fwd_word_ff : rd_word;
      a_cur      = cur_word[c3sf_pkg::PIX_W-1:0];
      b_cur      = cur_word[c3sf_pkg::WORD_W-1:c3sf_pkg::PIX_W];
      wr_word    = {a_cur, s1_pix_ff};
      col_new[0] = b_cur;
      col_new[1] = a_cur;
      col_new[2] = s1_pix_ff;
   end

   c3sf_window u_window (
      .clock    (clock),
      .reset    (reset),
      .shift_en (s1_wr),
      .col_new  (col_new),
      .win_new  (win_new)
   );

   // ------------------------------------------------------------------------
   // stages 2 to output
   // ------------------------------------------------------------------------
   assign mac_ctl = '{ld_s2: rdy2, ld_s3: rdy3, ld_s4: rdy4, ld_out: ld_out};

   c3sf_mac u_mac (
      .clock      (clock),
      .ctl        (mac_ctl),
      .win        (win_new),
      .mask       (s1_mask_ff),
      .last       (s1_last_ff),
      .coefs      (coef_ff),
      .pixel_out  (rsp_pixel_out),
      .frame_last (rsp_frame_last)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rdy2) begin
            v2_ff <= s1_v_ff && s1_emit_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
         if (rdy4) begin
            v4_ff <= v3_ff;
         end
         if (ld_out) begin
            rsp_valid_ff <= v4_ff;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      GW'(col_ff) < w_eff_ff)
      else $error("column counter reached image width");

   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      row_ff <= h_eff_ff + ONE_GEO)
      else $error("row counter ran past the drain rows");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (proc && last) |=> (col_ff == '0) && (row_ff == '0))
      else $error("positions not cleared after frame end");

   a_fwd_needs_write: assert property (@(posedge clock) disable iff (reset)
      (rdy1 && fwd_in) |=> s1_fwd_ff && ($past(s1_addr_ff) == s1_addr_ff))
      else $error("forwarded word taken without a matching write");

endmodule

@@ tb/conv3x3_stream_filter_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// conv3x3_stream_filter_unit_test: self-checking bench for the 3x3 filter
// Feeds frames in raster order, then tail items that flush the last rows.
// Each accepted item runs through a local line-store and window model that
// predicts the filtered pixel and end-of-frame flag. Covers zero padding and
// forced-zero borders, clamping, ignored drains, pixels past the frame end,
// geometry rewrites in mid-frame and the width and height limits. The sender
// runs in bursts with random gaps and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module conv3x3_stream_filter_unit_test;

   localparam int LINE_LEN       = 1024;
   localparam int RANDOM_ITEMS   = 320;
   localparam int SETTLE_CYCLES  = 10;
   localparam int WATCHDOG_LIMIT = 1000;

   localparam logic ACT_PIXEL = 1'b0;
   localparam logic ACT_DRAIN = 1'b1;

   localparam logic [c3sf_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [c3sf_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam int COEF_FULL    = 0;
   localparam int COEF_SMALL   = 1;
   localparam int COEF_EXTREME = 2;

   typedef struct packed {
      c3sf_pkg::pix_type pixel;
      logic              last;
   } filt_out_type;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic                            req_action;
   c3sf_pkg::pix_type               req_pixel_in;
   logic                            rsp_valid;
   logic                            rsp_stall;
   c3sf_pkg::pix_type               rsp_pixel_out;
   logic                            rsp_frame_last;
   logic                            csr_write_en;
   logic [c3sf_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [c3sf_pkg::CSR_DATA_W-1:0] csr_data;

   // filter model state
   logic [c3sf_pkg::IMG_W_W-1:0] geo_width;
   logic [c3sf_pkg::IMG_H_W-1:0] geo_height;
   logic                         border_zero;
   logic [c3sf_pkg::ROW_W-1:0]   coef_rows [c3sf_pkg::KS];
   c3sf_pkg::pix_type            line_a [LINE_LEN];
   c3sf_pkg::pix_type            line_b [LINE_LEN];
   c3sf_pkg::pix_type            win [c3sf_pkg::KS][c3sf_pkg::KS];
   int                           next_col;
   int                           next_row;

   filt_out_type expected_pixels [$];

   int          fail_count = 0;
   int          idle_cycles = 0;
   int          burst_left = 1;
   bit          gaps_on = 1'b1;
   logic [31:0] stall_cycle = '0;
   int          stall_hold = 0;

   conv3x3_stream_filter_unit #(
      .MAX_WIDTH(LINE_LEN)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_pixel_in   (req_pixel_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_frame_last (rsp_frame_last),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int coef_at(input int kr, input int kc);
      logic signed [c3sf_pkg::COEF_W-1:0] cf;
      cf = coef_rows[kr][c3sf_pkg::COEF_W*kc +: c3sf_pkg::COEF_W];
      return int'(cf);
   endfunction

   function automatic c3sf_pkg::pix_type filter_value(input int ro, input int co,
                                                      input int base, input int w,
                                                      input int h);
      int acc;
      int ir;
      int ic;
      acc = 0;
      if (border_zero && (ro == 0 || co == 0 || ro == h - 1 || co == w - 1))
         return '0;
      for (int kr = 0; kr < c3sf_pkg::KS; kr++) begin
         ir = ro - 1 + kr;
         if (ir >= 0 && ir < h) begin
            for (int kc = 0; kc < c3sf_pkg::KS; kc++) begin
               ic = co - 1 + kc;
               if (ic >= 0 && ic < w && base + kc <= c3sf_pkg::HALF_K)
                  acc += int'(win[kr][base + kc]) * coef_at(kr, kc);
            end
         end
      end
      if (acc < 0)
         return '0;
      acc = acc >>> c3sf_pkg::FRAC_W;
      return (acc > 255) ? c3sf_pkg::PIX_MAX : acc[c3sf_pkg::PIX_W-1:0];
   endfunction

   task automatic predict_filter_step(input logic act, input c3sf_pkg::pix_type pix_in);
      int w;
      int h;
      int r;
      int c;
      int ro;
      int co;
      bit emit;
      c3sf_pkg::pix_type pix;
      c3sf_pkg::pix_type a;
      c3sf_pkg::pix_type b;
      filt_out_type res;
      w = (geo_width == 0) ? 1 : ((int'(geo_width) > LINE_LEN) ? LINE_LEN : int'(geo_width));
      h = (geo_height == 0) ? 1 :
          ((int'(geo_height) > c3sf_pkg::MAX_HEIGHT) ? c3sf_pkg::MAX_HEIGHT :
           int'(geo_height));
      r = next_row;
      c = next_col;
      emit = 1'b0;
      ro = 0;
      co = 0;
      pix = pix_in;
      if (act == ACT_DRAIN && r < h)
         return;
      if (r >= h)
         pix = '0;
      if (c >= w)
         c = 0;
      if (c == 0 && r >= 2) begin
         emit = 1'b1;
         ro = r - 2;
         co = w - 1;
         res.pixel = filter_value(ro, co, 1, w, h);
      end
      a = line_a[c];
      b = line_b[c];
      line_b[c] = a;
      line_a[c] = pix;
      for (int k = 0; k < c3sf_pkg::KS; k++) begin
         win[k][0] = win[k][1];
         win[k][1] = win[k][2];
      end
      win[0][c3sf_pkg::HALF_K] = b;
      win[1][c3sf_pkg::HALF_K] = a;
      win[2][c3sf_pkg::HALF_K] = pix;
      if (c >= 1 && r >= 1) begin
         emit = 1'b1;
         ro = r - 1;
         co = c - 1;
         res.pixel = filter_value(ro, co, 0, w, h);
      end
      c++;
      if (c >= w) begin
         c = 0;
         r++;
      end
      next_col = c;
      next_row = r;
      if (emit) begin
         res.last = (ro == h - 1 && co == w - 1);
         if (res.last) begin
            next_col = 0;
            next_row = 0;
         end
         expected_pixels.push_back(res);
      end
   endtask

   task automatic pause_sender(input int gap);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (gap - 1) @(negedge clock);
   endtask

   task automatic send_item(input logic act, input c3sf_pkg::pix_type pix);
      @(negedge clock);
      req_valid    <= 1'b1;
      req_action   <= act;
      req_pixel_in <= pix;
      do @(posedge clock); while (req_stall);
      predict_filter_step(act, pix);
      if (burst_left > 0)
         burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (gaps_on)
            pause_sender($urandom_range(1, 6));
      end
   endtask

   task automatic wait_results_done();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [c3sf_pkg::CSR_IDX_W-1:0] idx,
                            input logic [c3sf_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         c3sf_pkg::CSR_IMAGE_WIDTH: begin
            geo_width = data[c3sf_pkg::IMG_W_W-1:0];
            next_col = 0;
            next_row = 0;
         end
         c3sf_pkg::CSR_IMAGE_HEIGHT: begin
            geo_height = data[c3sf_pkg::IMG_H_W-1:0];
            next_col = 0;
            next_row = 0;
         end
         c3sf_pkg::CSR_BORDER_MODE: border_zero = data[0];
         c3sf_pkg::CSR_COEF_TOP:    coef_rows[0] = data;
         c3sf_pkg::CSR_COEF_MID:    coef_rows[1] = data;
         c3sf_pkg::CSR_COEF_BOT:    coef_rows[2] = data;
         default: ;
      endcase
   endtask

   task automatic set_geometry(input int w, input int h);
      logic [63:0] junk;
      junk = {$urandom(), $urandom()};
      if ($urandom_range(0, 1) == 0)
         junk = '0;
      write_reg(c3sf_pkg::CSR_IMAGE_WIDTH,
                {junk[c3sf_pkg::CSR_DATA_W-1:c3sf_pkg::IMG_W_W], w[c3sf_pkg::IMG_W_W-1:0]});
      write_reg(c3sf_pkg::CSR_IMAGE_HEIGHT,
                {junk[c3sf_pkg::CSR_DATA_W-1:c3sf_pkg::IMG_H_W], h[c3sf_pkg::IMG_H_W-1:0]});
   endtask

   task automatic set_border(input logic zero_edges);
      write_reg(c3sf_pkg::CSR_BORDER_MODE, {{(c3sf_pkg::CSR_DATA_W-1){1'b0}}, zero_edges});
   endtask

   function automatic logic [c3sf_pkg::ROW_W-1:0] rand_coef_row(input int kind);
      logic [c3sf_pkg::ROW_W-1:0] row;
      int v;
      for (int k = 0; k < c3sf_pkg::KS; k++) begin
         case (kind)
            COEF_FULL:  v = $urandom_range(0, 65535);
            COEF_SMALL: v = $urandom_range(0, 8192) - 4096;
            default: begin
               case ($urandom_range(0, 4))
                  0:       v = 32'h7FFF;
                  1:       v = 32'h8000;
                  2:       v = 32'h1000;
                  3:       v = 32'hF000;
                  default: v = 0;
               endcase
            end
         endcase
         row[c3sf_pkg::COEF_W*k +: c3sf_pkg::COEF_W] = v[c3sf_pkg::COEF_W-1:0];
      end
      return row;
   endfunction

   task automatic write_coefs(input int kind);
      write_reg(c3sf_pkg::CSR_COEF_TOP, rand_coef_row(kind));
      write_reg(c3sf_pkg::CSR_COEF_MID, rand_coef_row(kind));
      write_reg(c3sf_pkg::CSR_COEF_BOT, rand_coef_row(kind));
   endtask

   function automatic c3sf_pkg::pix_type rand_pixel();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return c3sf_pkg::PIX_MAX;
         default: return c3sf_pkg::pix_type'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_tail(input int count);
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(0, 1) == 0)
            send_item(ACT_DRAIN, rand_pixel());
         else
            send_item(ACT_PIXEL, rand_pixel());
      end
   endtask

   task automatic test_directed_frames();
      // default middle row and border mode, heavy outer rows
      set_geometry(3, 3);
      write_reg(c3sf_pkg::CSR_COEF_TOP, {16'h7FFF, 16'h7FFF, 16'h7FFF});
      write_reg(c3sf_pkg::CSR_COEF_BOT, {16'h8000, 16'h8000, 16'h8000});
      send_item(ACT_DRAIN, c3sf_pkg::PIX_MAX);
      for (int k = 0; k < 9; k++)
         send_item(ACT_PIXEL, (k % 2 == 0) ? c3sf_pkg::PIX_MAX : c3sf_pkg::pix_type'(0));
      send_item(ACT_PIXEL, c3sf_pkg::PIX_MAX);
      send_item(ACT_DRAIN, '0);
      send_item(ACT_PIXEL, 8'h5A);
      send_item(ACT_DRAIN, c3sf_pkg::PIX_MAX);
      wait_results_done();
      // unused indexes must leave every register alone
      write_reg(CSR_SPARE_LO, '1);
      write_reg(CSR_SPARE_HI, '1);
      set_border(1'b1);
      write_reg(c3sf_pkg::CSR_COEF_MID, {16'h7FFF, 16'h8000, 16'h7FFF});
      for (int k = 0; k < 9; k++)
         send_item(ACT_PIXEL, (k % 2 == 0) ? c3sf_pkg::pix_type'(0) : c3sf_pkg::PIX_MAX);
      send_tail(4);
      wait_results_done();
   endtask

   task automatic test_random_frames();
      int counted;
      int w;
      int h;
      int n_pix;
      bit broken;
      bit reconf;
      counted = 0;
      reconf = 1'b1;
      w = 1;
      h = 1;
      while (counted < RANDOM_ITEMS) begin
         if (reconf) begin
            wait_results_done();
            case ($urandom_range(0, 9))
               0:       w = 1;
               1:       w = 2;
               default: w = $urandom_range(3, 12);
            endcase
            h = $urandom_range(1, 6);
            set_geometry(w, h);
            set_border($urandom_range(0, 1) == 1);
            if ($urandom_range(0, 2) != 0)
               write_coefs($urandom_range(COEF_FULL, COEF_EXTREME));
         end
         gaps_on = ($urandom_range(0, 3) != 0);
         broken = ($urandom_range(0, 7) == 0);
         n_pix = w * h;
         if (broken)
            n_pix = $urandom_range(0, n_pix - 1);
         for (int k = 0; k < n_pix; k++) begin
            if ($urandom_range(0, 19) == 0)
               send_item(ACT_DRAIN, rand_pixel());
            send_item(ACT_PIXEL, rand_pixel());
            counted++;
            if ($urandom_range(0, 99) == 0)
               wait_results_done();
         end
         if (!broken) begin
            send_tail(w + 1);
            counted += w + 1;
         end
         reconf = broken || ($urandom_range(0, 1) == 0);
      end
      wait_results_done();
   endtask

   task automatic run_frame(input int w, input int h);
      for (int k = 0; k < w * h; k++)
         send_item(ACT_PIXEL, rand_pixel());
      send_tail(w + 1);
   endtask

   task automatic test_geometry_extremes();
      gaps_on = 1'b1;
      // width and height of zero act as one
      set_geometry(0, 0);
      set_border(1'b0);
      write_coefs(COEF_SMALL);
      repeat (3) run_frame(1, 1);
      wait_results_done();
      // oversized height saturates to the maximum row count
      set_geometry(1, 8191);
      write_coefs(COEF_FULL);
      for (int k = 0; k < 40; k++)
         send_item(ACT_PIXEL, rand_pixel());
      wait_results_done();
      // oversized width saturates to the line length
      set_geometry(2047, 2);
      set_border(1'b1);
      write_coefs(COEF_EXTREME);
      for (int k = 0; k < 24; k++)
         send_item(ACT_PIXEL, rand_pixel());
      wait_results_done();
   endtask

   always @(negedge clock) begin
      stall_cycle <= stall_cycle + 1;
      case (stall_cycle[9:8])
         2'd0: rsp_stall <= 1'b0;
         2'd1: rsp_stall <= ($urandom_range(0, 1) == 1);
         2'd2: rsp_stall <= (stall_cycle[2:0] < 3'd3);
         default: begin
            if (stall_hold > 0) begin
               rsp_stall  <= 1'b1;
               stall_hold <= stall_hold - 1;
            end else if ($urandom_range(0, 15) == 0) begin
               rsp_stall  <= 1'b1;
               stall_hold <= $urandom_range(5, 30);
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      endcase
   end

   always @(posedge clock) begin : check_results
      filt_out_type exp_px;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected result: pixel_out %0d frame_last %0b",
                   rsp_pixel_out, rsp_frame_last);
            fail_count++;
         end else begin
            exp_px = expected_pixels.pop_front();
            if (rsp_pixel_out !== exp_px.pixel) begin
               $error("pixel_out mismatch: expected %0d, actual %0d",
                      exp_px.pixel, rsp_pixel_out);
               fail_count++;
            end
            if (rsp_frame_last !== exp_px.last) begin
               $error("frame_last mismatch: expected %0b, actual %0b",
                      exp_px.last, rsp_frame_last);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_action   = ACT_PIXEL;
      req_pixel_in = '0;
      rsp_stall    = 1'b0;
      csr_write_en = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      geo_width    = c3sf_pkg::WIDTH_RST[c3sf_pkg::IMG_W_W-1:0];
      geo_height   = c3sf_pkg::HEIGHT_RST[c3sf_pkg::IMG_H_W-1:0];
      border_zero  = 1'b0;
      coef_rows[0] = c3sf_pkg::COEF_TOP_RST;
      coef_rows[1] = c3sf_pkg::COEF_MID_RST;
      coef_rows[2] = c3sf_pkg::COEF_BOT_RST;
      for (int k = 0; k < LINE_LEN; k++) begin
         line_a[k] = '0;
         line_b[k] = '0;
      end
      for (int kr = 0; kr < c3sf_pkg::KS; kr++)
         for (int kc = 0; kc < c3sf_pkg::KS; kc++)
            win[kr][kc] = '0;
      next_col = 0;
      next_row = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_frames();
      test_random_frames();
      test_geometry_extremes();

      wait_results_done();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && expected_pixels.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/c3sf_pkg.sv
hw/rtl/c3sf_line_mem.sv
hw/rtl/c3sf_window.sv
hw/rtl/c3sf_mac.sv
hw/rtl/conv3x3_stream_filter_unit.sv
tb/conv3x3_stream_filter_unit_test.sv
